[hdl/substring_search_unit_defines.svh]
// Assertion macros shared by the substring search unit checkers.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef SUBSTRING_SEARCH_UNIT_DEFINES_SVH
`define SUBSTRING_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define SSU_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("substring search unit check failed");

// next-cycle implication
`define SSU_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("substring search unit check failed");

`endif

[hdl/sss_pkg.sv]
// Shared types, register indexes and helpers for the substring search unit.
// No dependencies.
`default_nettype none

package sss_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int LEN_WIDTH     = 5;
   localparam int INDEX_WIDTH   = 3;
   localparam int DATA_WIDTH    = 64;
   localparam int START_WIDTH   = 16;
   localparam int RESULT_WIDTH  = 16;

   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_PATTERN_LOW    = 3'd0,
      REG_PATTERN_HIGH   = 3'd1,
      REG_PATTERN_LENGTH = 3'd2,
      REG_IGNORE_CASE    = 3'd3,
      REG_SEARCH_LAST    = 3'd4,
      REG_START_POSITION = 3'd5
   } reg_index_type;

   typedef logic [PATTERN_BYTES-1:0][7:0] pattern_type;

   typedef struct packed {
      pattern_type            pattern;
      logic [LEN_WIDTH-1:0]   length;
      logic                   ignore_case;
      logic                   search_last;
      logic [START_WIDTH-1:0] start_position;
   } cfg_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic ignore);
      logic [7:0] r;
      r = c;
      if (ignore && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/sss_csr.sv]
// Configuration registers of the substring search unit, with length clamp.
// Depends on sss_pkg.
`default_nettype none

module sss_csr #(
   parameter int MAX_PATTERN = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sss_pkg::INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [sss_pkg::DATA_WIDTH-1:0]    csr_data,
   output sss_pkg::cfg_type                       cfg
);

   localparam int LEN_CAP = (MAX_PATTERN < sss_pkg::PATTERN_BYTES) ?
                            MAX_PATTERN : sss_pkg::PATTERN_BYTES;

   sss_pkg::pattern_type                   pattern_ff;
   logic [sss_pkg::LEN_WIDTH-1:0]          length_ff;
   logic                                   ignore_ff;
   logic                                   last_ff;
   logic [sss_pkg::START_WIDTH-1:0]        start_ff;
   logic                                   write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
         ignore_ff  <= 1'b0;
         last_ff    <= 1'b0;
         start_ff   <= '0;
      end else if (write) begin
         case (sss_pkg::reg_index_type'(csr_index))
            sss_pkg::REG_PATTERN_LOW: begin
               pattern_ff[7:0] <= csr_data;
            end
            sss_pkg::REG_PATTERN_HIGH: begin
               pattern_ff[15:8] <= csr_data;
            end
            sss_pkg::REG_PATTERN_LENGTH: begin
               length_ff <= csr_data[sss_pkg::LEN_WIDTH-1:0];
            end
            sss_pkg::REG_IGNORE_CASE: begin
               ignore_ff <= csr_data[0];
            end
            sss_pkg::REG_SEARCH_LAST: begin
               last_ff <= csr_data[0];
            end
            sss_pkg::REG_START_POSITION: begin
               start_ff <= csr_data[sss_pkg::START_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.pattern        = pattern_ff;
      cfg.length         = (length_ff > sss_pkg::LEN_WIDTH'(LEN_CAP)) ?
                           sss_pkg::LEN_WIDTH'(LEN_CAP) : length_ff;
      cfg.ignore_case    = ignore_ff;
      cfg.search_last    = last_ff;
      cfg.start_position = start_ff;
   end

endmodule

`default_nettype wire

[hdl/sss_cell.sv]
// One window cell: holds the byte seen INDEX+1 requests ago and compares the
// incoming byte with its aligned pattern byte. Depends on sss_pkg.
`default_nettype none

module sss_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic                           shift,
   input  wire logic [7:0]                     byte_in,
   input  wire sss_pkg::pattern_type           pattern,
   input  wire logic [sss_pkg::LEN_WIDTH-1:0]  length,
   input  wire logic                           ignore_case,
   output logic [7:0]                          byte_out,
   output logic                                eq_out
);

   localparam logic [6:0] CELL_POS = 7'(INDEX);

   logic [7:0] byte_ff;
   logic       eq_ff;
   logic       eq_in;
   logic       active;
   logic [6:0] slot;

   // cell k lines up with pattern byte length-1-k
   assign active = 7'(length) > CELL_POS;
   assign slot   = 7'(length) - CELL_POS - 7'd1;
   assign eq_in  = !active ||
                   (sss_pkg::fold(byte_in, ignore_case) ==
                    sss_pkg::fold(pattern[slot[3:0]], ignore_case));

   always_ff @(posedge clock) begin
      if (load) begin
         eq_ff <= eq_in;
      end
      if (load && shift) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;
   assign eq_out   = eq_ff;

endmodule

`default_nettype wire

[hdl/substring_search_unit.sv]
// Top level of the substring search unit: cell chain, match tracking, result register.
// Depends on sss_pkg, sss_csr and sss_cell.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    text_byte, end_of_text
//   rsp      out        rsp_valid/stall    found, match_position
//   csr      in         csr_valid/ready    index, data
//
// One text byte is taken per cycle while req_stall is low; the cell row compares it on entry.
// After the final byte is taken, the result passes the cell stage, then the result reg.
// req_stall rises only when a finished request waits behind a stalled result.
// Synchronous reset clears configuration, counters and the result valid flag; window bytes need none.
`default_nettype none

module substring_search_unit #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_text_byte,
   input  wire logic                                req_end_of_text,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_found,
   output logic [sss_pkg::RESULT_WIDTH-1:0]         rsp_match_position,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sss_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [sss_pkg::DATA_WIDTH-1:0]      csr_data
);

   localparam int CMP_W = (POSITION_BITS > sss_pkg::START_WIDTH) ?
                          POSITION_BITS : sss_pkg::START_WIDTH;

   sss_pkg::cfg_type cfg;

   logic [7:0]               chain   [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]   eq;

   logic [POSITION_BITS-1:0] count_ff,  count_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff;
   logic                     s1_shift_ff;
   logic [POSITION_BITS-1:0] s1_count_ff;
   logic                     have_ff,   have_in;
   logic [POSITION_BITS-1:0] chosen_ff, chosen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff,  found_in;
   logic [sss_pkg::RESULT_WIDTH-1:0] pos_ff, pos_in;

   logic                     accept;
   logic                     shift;
   logic [POSITION_BITS-1:0] count_next;
   logic                     hold;
   logic                     fire;
   logic                     empty_pattern;
   logic [POSITION_BITS-1:0] len_ext;
   logic                     hit;
   logic                     qualify;
   logic                     upd;
   logic                     have_next;
   logic [POSITION_BITS-1:0] chosen_next;
   logic [63:0]              wide_pos;

   sss_csr #(.MAX_PATTERN(MAX_PATTERN)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign hold      = s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall;
   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;
   assign fire      = s1_valid_ff && !hold;

   // bytes past the saturated count are not shifted in
   assign shift      = count_ff != '1;
   assign count_next = shift ? count_ff + 1'b1 : count_ff;

   assign chain[0] = req_text_byte;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      sss_cell #(.INDEX(k)) u_cell (
         .clock       (clock),
         .load        (accept),
         .shift       (shift),
         .byte_in     (chain[k]),
         .pattern     (cfg.pattern),
         .length      (cfg.length),
         .ignore_case (cfg.ignore_case),
         .byte_out    (chain[k+1]),
         .eq_out      (eq[k])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = req_end_of_text ? '0 : count_next;
      end
      s1_valid_in = accept || hold;
   end

   always_comb begin
      empty_pattern = cfg.length == '0;
      len_ext       = POSITION_BITS'(cfg.length);
      hit           = !empty_pattern && s1_shift_ff && (s1_count_ff >= len_ext) && (&eq);
      chosen_next   = s1_count_ff - len_ext;
      if (cfg.search_last) begin
         qualify = CMP_W'(chosen_next) <= CMP_W'(cfg.start_position);
      end else begin
         qualify = !have_ff && (CMP_W'(chosen_next) >= CMP_W'(cfg.start_position));
      end
      upd       = hit && qualify;
      have_next = have_ff || upd;
      if (!upd) begin
         chosen_next = chosen_ff;
      end

      have_in   = have_ff;
      chosen_in = chosen_ff;
      if (fire) begin
         have_in   = s1_last_ff ? 1'b0 : have_next;
         chosen_in = s1_last_ff ? '0 : chosen_next;
      end

      if (empty_pattern) begin
         wide_pos = cfg.search_last ? 64'(s1_count_ff) : 64'd0;
         found_in = 1'b1;
      end else begin
         wide_pos = have_next ? 64'(chosen_next) : 64'd0;
         found_in = have_next;
      end
      pos_in = wide_pos[sss_pkg::RESULT_WIDTH-1:0];

      if (fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         chosen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         have_ff      <= have_in;
         chosen_ff    <= chosen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff  <= req_end_of_text;
         s1_shift_ff <= shift;
         s1_count_ff <= count_next;
      end
      if (fire && s1_last_ff) begin
         found_ff <= found_in;
         pos_ff   <= pos_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_match_position = pos_ff;

endmodule

`default_nettype wire

[hdl/sss_checker.sv]
// Port-level checks for the substring search unit, bound to the top level.
// Depends on substring_search_unit_defines.svh and substring_search_unit.
`default_nettype none
`include "substring_search_unit_defines.svh"

module sss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_end_of_text,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_found,
   input wire logic [15:0] rsp_match_position
);

   `SSU_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)
   `SSU_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_found) && $stable(rsp_match_position))
   `SSU_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_found, rsp_match_position == 16'd0)
   `SSU_ASSERT_NOW(a_rsp_after_last, $rose(rsp_valid), $past(req_valid && !req_stall && req_end_of_text, 2))
   `SSU_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

endmodule

bind substring_search_unit sss_checker u_sss_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_end_of_text    (req_end_of_text),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_found          (rsp_found),
   .rsp_match_position (rsp_match_position)
);

`default_nettype wire

[verif/substring_search_checker.sv]
// Checker for the substring search unit: follows the csr, req and rsp channels, predicts the
// outcome of each finished text and compares it with the unit's result.
// Depends on sss_pkg.
module substring_search_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_stall,
   input  logic [7:0]                                req_text_byte,
   input  logic                                      req_end_of_text,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   input  logic                                      rsp_found,
   input  logic [sss_pkg::RESULT_WIDTH-1:0]          rsp_match_position,
   input  logic                                      csr_valid,
   input  logic                                      csr_ready,
   input  logic [sss_pkg::INDEX_WIDTH-1:0]           csr_index,
   input  logic [sss_pkg::DATA_WIDTH-1:0]            csr_data,
   output int                                        failures,
   output int                                        outstanding
);

   typedef struct packed {
      logic                             found;
      logic [sss_pkg::RESULT_WIDTH-1:0] position;
   } outcome_type;

   outcome_type outcomes [$];

   logic [63:0]                     pat_lo;
   logic [63:0]                     pat_hi;
   logic [sss_pkg::LEN_WIDTH-1:0]   pat_len;
   logic                            fold_case;
   logic                            find_last;
   logic [sss_pkg::START_WIDTH-1:0] start_pos;

   logic [7:0]  text_window [sss_pkg::PATTERN_BYTES];
   logic [15:0] text_count;
   logic        match_held;
   logic [15:0] match_start;

   int fail_count = 0;

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      if (fold_case && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] pattern_at(input int j);
      logic [63:0] w;
      w = (j < 8) ? pat_lo : pat_hi;
      return w[(j % 8) * 8 +: 8];
   endfunction

   task automatic clear_text();
      for (int k = 0; k < sss_pkg::PATTERN_BYTES; k++) begin
         text_window[k] = 8'h00;
      end
      text_count  = '0;
      match_held  = 1'b0;
      match_start = '0;
   endtask

   task automatic write_reg(input logic [sss_pkg::INDEX_WIDTH-1:0] index,
                            input logic [63:0] data);
      case (sss_pkg::reg_index_type'(index))
         sss_pkg::REG_PATTERN_LOW:    pat_lo    = data;
         sss_pkg::REG_PATTERN_HIGH:   pat_hi    = data;
         sss_pkg::REG_PATTERN_LENGTH: pat_len   = data[sss_pkg::LEN_WIDTH-1:0];
         sss_pkg::REG_IGNORE_CASE:    fold_case = data[0];
         sss_pkg::REG_SEARCH_LAST:    find_last = data[0];
         sss_pkg::REG_START_POSITION: start_pos = data[sss_pkg::START_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      int          len;
      bit          same;
      logic [15:0] p;
      outcome_type o;
      len = (pat_len > sss_pkg::PATTERN_BYTES) ? sss_pkg::PATTERN_BYTES : int'(pat_len);
      // the count saturates; bytes past it take no part in matching
      if (text_count != 16'hFFFF) begin
         for (int k = sss_pkg::PATTERN_BYTES - 1; k > 0; k--) begin
            text_window[k] = text_window[k-1];
         end
         text_window[0] = b;
         text_count = text_count + 16'd1;
         if (len > 0 && text_count >= len) begin
            same = 1'b1;
            for (int j = 0; j < len; j++) begin
               if (lower_ascii(text_window[len-1-j]) != lower_ascii(pattern_at(j))) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               p = text_count - 16'(len);
               if (find_last) begin
                  if (p <= start_pos) begin
                     match_held  = 1'b1;
                     match_start = p;
                  end
               end else if (!match_held && p >= start_pos) begin
                  match_held  = 1'b1;
                  match_start = p;
               end
            end
         end
      end
      if (last) begin
         if (len == 0) begin
            o.found    = 1'b1;
            o.position = find_last ? text_count : '0;
         end else begin
            o.found    = match_held;
            o.position = match_held ? match_start : '0;
         end
         outcomes.push_back(o);
         clear_text();
      end
   endtask

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         pat_lo    = '0;
         pat_hi    = '0;
         pat_len   = '0;
         fold_case = 1'b0;
         find_last = 1'b0;
         start_pos = '0;
         clear_text();
         outcomes.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            write_reg(csr_index, csr_data);
         end
         if (req_valid && !req_stall) begin
            take_byte(req_text_byte, req_end_of_text);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_found, rsp_match_position};
            if (outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("result with no request pending: found %0d position %0d",
                           got.found, got.position);
               end
            end else begin
               want = outcomes.pop_front();
               if (got.found != want.found || got.position != want.position) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: found exp %0d got %0d, position exp %0d got %0d",
                              want.found, got.found, want.position, got.position);
                  end
               end
            end
         end
         outstanding <= outcomes.size();
      end
      failures <= fail_count;
   end

endmodule

[verif/substring_search_unit_test.sv]
// Testbench top for the substring search unit: clock, reset, text and register stimulus,
// receiver stalls and the final verdict. Depends on sss_pkg, substring_search_unit and
// substring_search_checker.
module substring_search_unit_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 16;
   localparam int PHASE_BYTES = 100;
   localparam logic [sss_pkg::INDEX_WIDTH-1:0] REG_SPARE = 3'd6;

   typedef enum int {PACE_STEADY, PACE_SPARSE_SEND, PACE_SLOW_SINK, PACE_BOTH} pace_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_text_byte = 8'h00;
   logic                             req_end_of_text = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_found;
   logic [sss_pkg::RESULT_WIDTH-1:0] rsp_match_position;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [sss_pkg::INDEX_WIDTH-1:0]  csr_index = '0;
   logic [sss_pkg::DATA_WIDTH-1:0]   csr_data = '0;
   int                               failures;
   int                               outstanding;

   int   send_gap_pct = 0;
   int   stall_pct = 0;
   bit   hold_off = 1'b0;
   int   hold_count = 0;

   logic [7:0] pattern_bytes [sss_pkg::PATTERN_BYTES];
   int         pattern_len = 0;
   bit         fold_on = 1'b0;
   bit         alpha_mode = 1'b1;
   logic [7:0] text_buf [$];

   substring_search_unit u_top (.*);

   substring_search_checker u_checker (.*);

   always #5 clock = ~clock;

   // receiver: one long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (hold_off && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("substring_search_unit_test failed");
      $finish;
   end

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(4))
         0: return 8'h61;
         1: return 8'h62;
         2: return 8'h41;
         3: return 8'h42;
         default: return 8'h63;
      endcase
   endfunction

   function automatic logic [7:0] background();
      return alpha_mode ? pick_letter() : 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] vary_case(input logic [7:0] c);
      bit letter;
      letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      if (fold_on && letter && $urandom_range(1)) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   task automatic set_pace(input pace_type mode);
      case (mode)
         PACE_STEADY:      begin send_gap_pct = 0;  stall_pct <= 0;  end
         PACE_SPARSE_SEND: begin send_gap_pct = 79; stall_pct <= 0;  end
         PACE_SLOW_SINK:   begin send_gap_pct = 0;  stall_pct <= 79; end
         default:          begin send_gap_pct = 38; stall_pct <= 38; end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_byte(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   // stop sending, let every request finish, then allow for the pipeline
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sss_pkg::INDEX_WIDTH-1:0] index,
                            input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [63:0] lo, input logic [63:0] hi, input int len,
                            input bit ic, input bit sl, input logic [15:0] st,
                            input bit spare);
      logic [63:0] noise;
      wait_quiet();
      noise = {$urandom, $urandom};
      if (spare) write_reg(REG_SPARE, noise);
      write_reg(sss_pkg::REG_PATTERN_LOW, lo);
      write_reg(sss_pkg::REG_PATTERN_HIGH, hi);
      write_reg(sss_pkg::REG_PATTERN_LENGTH,
                {noise[63:sss_pkg::LEN_WIDTH], sss_pkg::LEN_WIDTH'(len)});
      write_reg(sss_pkg::REG_IGNORE_CASE, {noise[63:1], ic});
      write_reg(sss_pkg::REG_SEARCH_LAST, {noise[62:0], sl});
      write_reg(sss_pkg::REG_START_POSITION, {noise[63:sss_pkg::START_WIDTH], st});
      csr_valid <= 1'b0;
      for (int j = 0; j < 8; j++) begin
         pattern_bytes[j]     = lo[j*8 +: 8];
         pattern_bytes[j + 8] = hi[j*8 +: 8];
      end
      pattern_len = len;
      fold_on     = ic;
   endtask

   task automatic random_setup();
      logic [63:0] lo;
      logic [63:0] hi;
      int          len;
      logic [15:0] st;
      alpha_mode = ($urandom_range(99) < 70);
      case ($urandom_range(7))
         0: len = 0;
         1: len = 16;
         2: len = 31;
         3: len = $urandom_range(17, 31);
         default: len = $urandom_range(1, 16);
      endcase
      case ($urandom_range(9))
         0: begin lo = '0; hi = '0; end
         1: begin lo = '1; hi = '1; end
         default: begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (alpha_mode) begin
               for (int j = 0; j < 8; j++) begin
                  lo[j*8 +: 8] = pick_letter();
                  hi[j*8 +: 8] = pick_letter();
               end
            end
         end
      endcase
      case ($urandom_range(5))
         0: st = '0;
         1: st = 16'hFFFF;
         2: st = 16'($urandom);
         default: st = 16'($urandom_range(0, 30));
      endcase
      configure(lo, hi, len, 1'($urandom_range(1)), 1'($urandom_range(1)), st, 1'b0);
   endtask

   // random text with copies of the pattern, some of them spoilt
   task automatic fill_text(input int longest);
      int n;
      int eff;
      int at;
      eff = (pattern_len > sss_pkg::PATTERN_BYTES) ? sss_pkg::PATTERN_BYTES : pattern_len;
      n = $urandom_range(1, longest);
      text_buf.delete();
      for (int i = 0; i < n; i++) text_buf.push_back(background());
      if (eff > 0 && $urandom_range(99) < 80) begin
         repeat ($urandom_range(1, 3)) begin
            if (eff <= n) begin
               at = $urandom_range(0, n - eff);
               for (int j = 0; j < eff; j++) text_buf[at + j] = vary_case(pattern_bytes[j]);
               if ($urandom_range(9) == 0) begin
                  text_buf[at + $urandom_range(0, eff - 1)] = background();
               end
            end
         end
      end
   endtask

   initial begin
      int sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // exact "ab", forward from zero; text shorter than the pattern
      configure(64'h6261, 64'h0, 2, 1'b0, 1'b0, 16'h0000, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      send_byte(8'hFF, 1'b1);

      // case folded, last match with start zero: only position zero counts
      configure(64'h4241, '1, 2, 1'b1, 1'b1, 16'h0000, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      send_byte(8'h63, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);

      // empty pattern, reverse then forward
      configure(64'h0, 64'h0, 0, 1'b0, 1'b1, 16'h0000, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      configure('1, '1, 0, 1'b1, 1'b0, 16'hFFFF, 1'b0);
      send_byte(8'h41, 1'b1);

      // exact compare, last match below the top limit
      configure(64'h4241, 64'h0, 2, 1'b0, 1'b1, 16'hFFFF, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         random_setup();
         set_pace(pace_type'(phase % 4));
         sent = 0;
         while (sent < PHASE_BYTES) begin
            fill_text(((pattern_len > sss_pkg::PATTERN_BYTES) ?
                       sss_pkg::PATTERN_BYTES : pattern_len) + 24);
            send_text();
            sent += text_buf.size();
         end
      end

      // long hold-off on the result side while short texts keep coming
      random_setup();
      set_pace(PACE_STEADY);
      hold_off <= 1'b1;
      sent = 0;
      while (sent < 150) begin
         fill_text(2);
         send_text();
         sent += text_buf.size();
      end

      wait_quiet();
      repeat (4) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("substring_search_unit_test passed");
      end else begin
         $display("substring_search_unit_test failed");
      end
      $finish;
   end

endmodule
